>>> rtl/utf32_to_utf8_utf16_encoder_top_defines.svh
// ----------------------------------------------------------------------------
// utf32_to_utf8_utf16_encoder_top_defines.svh
// assertion macros shared by the encoder checks
// ----------------------------------------------------------------------------
`ifndef UTF32_TO_UTF8_UTF16_ENCODER_TOP_DEFINES_SVH
`define UTF32_TO_UTF8_UTF16_ENCODER_TOP_DEFINES_SVH

// property checked only outside reset
`define U32ENC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u32enc check failed");

// property checked at every edge, reset included
`define U32ENC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("u32enc reset check failed");

`endif

>>> rtl/u32enc_pkg.sv
// ----------------------------------------------------------------------------
// u32enc_pkg
// shared types and constants of the utf-32 to utf-8 / utf-16 encoder
// ----------------------------------------------------------------------------
package u32enc_pkg;

    // configuration register indexes
    typedef logic [1:0] cfg_idx_t;
    localparam cfg_idx_t CFG_OUTPUT_FORMAT     = 2'd0;
    localparam cfg_idx_t CFG_SRC_LITTLE_ENDIAN = 2'd1;
    localparam cfg_idx_t CFG_DST_LITTLE_ENDIAN = 2'd2;

    // output format codes
    localparam logic FMT_UTF8  = 1'b0;
    localparam logic FMT_UTF16 = 1'b1;

    // code point limits
    localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
    localparam logic [31:0] CP_BOM       = 32'h0000_FEFF;
    localparam logic [20:0] SURR_BLOCK   = 21'h00_001B;  // cp[31:11] of D800..DFFF
    localparam logic [20:0] SUPP_BASE    = 21'h01_0000;
    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;

    // configuration as seen by the classifier
    typedef struct packed {
        logic output_format;
        logic src_little_endian;
        logic dst_little_endian;
    } cfg_t;

    // one classified word: up to four units and the index of the last one
    typedef struct packed {
        logic [3:0][15:0] units;
        logic [1:0]       last_idx;
    } entry_t;

    // queue status toward both sides
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

>>> rtl/u32enc_front.sv
// ----------------------------------------------------------------------------
// u32enc_front
// holds the configuration registers, accepts a word and classifies it into
// a queue entry of ready-made units
// ----------------------------------------------------------------------------
module u32enc_front
    import u32enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  cfg_idx_t    cfg_index,
    input  logic        cfg_data,
    input  logic        start,
    input  logic [31:0] code_word,
    input  q_stat_t     q_stat,
    output logic        push,
    output entry_t      push_entry
);

    cfg_t        cfg_reg;
    cfg_t        cfg_next;
    logic [31:0] cp;
    logic        cp_ok;
    logic [19:0] supp_off;
    logic [3:0][15:0] units;
    logic [1:0]  last_idx;
    logic        has_units;

    // configuration writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_OUTPUT_FORMAT:     cfg_next.output_format     = cfg_data;
                CFG_SRC_LITTLE_ENDIAN: cfg_next.src_little_endian = cfg_data;
                CFG_DST_LITTLE_ENDIAN: cfg_next.dst_little_endian = cfg_data;
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // source byte order and validity
    assign cp = cfg_reg.src_little_endian
              ? {code_word[7:0], code_word[15:8], code_word[23:16], code_word[31:24]}
              : code_word;
    assign cp_ok    = (cp <= CP_MAX) && (cp[31:11] != SURR_BLOCK);
    assign supp_off = 20'(cp[20:0] - SUPP_BASE);

    // unit builder
    always_comb
    begin
        units     = '0;
        last_idx  = 2'd0;
        has_units = 1'b1;
        if (cfg_reg.output_format == FMT_UTF8)
        begin
            if (cp == '0)
            begin
                has_units = 1'b0;
            end
            else if (cp == CP_BOM)
            begin
                units[0] = 16'h00EF;
                units[1] = 16'h00BB;
                units[2] = 16'h00BF;
                last_idx = 2'd2;
            end
            else if (!cp_ok)
            begin
                units[0] = 16'h00EF;
                units[1] = 16'h00BF;
                units[2] = 16'h00BD;
                last_idx = 2'd2;
            end
            else if (cp[20:16] != '0)
            begin
                units[0] = {8'h00, 5'b11110, cp[20:18]};
                units[1] = {8'h00, 2'b10, cp[17:12]};
                units[2] = {8'h00, 2'b10, cp[11:6]};
                units[3] = {8'h00, 2'b10, cp[5:0]};
                last_idx = 2'd3;
            end
            else if (cp[15:11] != '0)
            begin
                units[0] = {8'h00, 4'b1110, cp[15:12]};
                units[1] = {8'h00, 2'b10, cp[11:6]};
                units[2] = {8'h00, 2'b10, cp[5:0]};
                last_idx = 2'd2;
            end
            else if (cp[10:7] != '0)
            begin
                units[0] = {8'h00, 3'b110, cp[10:6]};
                units[1] = {8'h00, 2'b10, cp[5:0]};
                last_idx = 2'd1;
            end
            else
            begin
                units[0] = {9'h000, cp[6:0]};
            end
        end
        else
        begin
            if (!cp_ok)
            begin
                units[0] = REPL_UNIT;
            end
            else if (cp[20:16] != '0)
            begin
                units[0] = HI_SURR_BASE | {6'd0, supp_off[19:10]};
                units[1] = LO_SURR_BASE | {6'd0, supp_off[9:0]};
                last_idx = 2'd1;
            end
            else
            begin
                units[0] = cp[15:0];
            end
            // destination byte order
            if (cfg_reg.dst_little_endian)
            begin
                units[0] = {units[0][7:0], units[0][15:8]};
                units[1] = {units[1][7:0], units[1][15:8]};
            end
        end
    end

    assign push             = start && !q_stat.full && has_units;
    assign push_entry.units    = units;
    assign push_entry.last_idx = last_idx;

endmodule

>>> rtl/u32enc_queue.sv
// ----------------------------------------------------------------------------
// u32enc_queue
// short fifo of classified words between the front and the back
// ----------------------------------------------------------------------------
module u32enc_queue
    import u32enc_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  head,
    output q_stat_t q_stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    entry_t        mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : PW'(wr_ptr_reg + 1'b1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : PW'(rd_ptr_reg + 1'b1);
        end
        if (push && !pop)
        begin
            cnt_next = CW'(cnt_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            cnt_next = CW'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign head         = mem_reg[rd_ptr_reg];
    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == FULL_CNT);

endmodule

>>> rtl/u32enc_back.sv
// ----------------------------------------------------------------------------
// u32enc_back
// walks the head entry one unit per cycle into the output register
// ----------------------------------------------------------------------------
module u32enc_back
    import u32enc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  entry_t      head,
    input  q_stat_t     q_stat,
    output logic        pop,
    output logic        out_valid,
    output logic [15:0] out_unit,
    output logic        is_last
);

    logic [1:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic        last_reg, last_next;
    logic [15:0] unit_reg, unit_next;
    logic        at_last;

    assign at_last = (idx_reg == head.last_idx);
    assign pop     = !q_stat.empty && at_last;

    // unit select and word position
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = 1'b0;
        last_next  = 1'b0;
        unit_next  = unit_reg;
        if (!q_stat.empty)
        begin
            valid_next = 1'b1;
            last_next  = at_last;
            unit_next  = head.units[idx_reg];
            idx_next   = at_last ? 2'd0 : 2'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        unit_reg <= unit_next;
    end

    assign out_valid = valid_reg;
    assign out_unit  = unit_reg;
    assign is_last   = last_reg;

endmodule

>>> rtl/utf32_to_utf8_utf16_encoder_top.sv
// An accepted start is written into the word queue; its first unit is then
// registered in the output register. Units leave at one per cycle while the
// queue holds a word; a word has 1 to 4 units, a zero word in utf-8 mode none.
// busy rises when the QUEUE_DEPTH-entry word queue is full; results never stall.
// Reset clears the three configuration registers to 0 and empties the queue.
// ----------------------------------------------------------------------------
// utf32_to_utf8_utf16_encoder_top
// utf-32 word in, utf-8 bytes or utf-16 units out, one unit per strobe
// ----------------------------------------------------------------------------
module utf32_to_utf8_utf16_encoder_top
    import u32enc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] code_word,
    output logic        out_valid,
    output logic [15:0] out_unit,
    output logic        is_last
);

    q_stat_t q_stat;
    logic    push;
    logic    pop;
    entry_t  push_entry;
    entry_t  head;

    // configuration writes are taken every cycle
    assign cfg_ready = 1'b1;
    assign busy      = q_stat.full;

    // classifier
    u32enc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .start      (start),
        .code_word  (code_word),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // word queue
    u32enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_stat     (q_stat)
    );

    // unit emitter
    u32enc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_stat    (q_stat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_unit  (out_unit),
        .is_last   (is_last)
    );

endmodule

>>> rtl/u32enc_checker.sv
// ----------------------------------------------------------------------------
// u32enc_checker
// port-level checks on the encoder top, attached by bind
// ----------------------------------------------------------------------------
`include "utf32_to_utf8_utf16_encoder_top_defines.svh"

module u32enc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        out_valid,
    input logic        is_last
);

    // no strobe while reset is held
    `U32ENC_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !out_valid)

    // the units of one word come out back to back
    `U32ENC_ASSERT(a_word_contiguous, out_valid && !is_last |=> out_valid)

    // the queue fills only from an accepted word
    `U32ENC_ASSERT(a_busy_after_start, $rose(busy) |-> $past(start))

    // is_last only marks a strobed unit
    `U32ENC_ASSERT(a_last_needs_valid, is_last |-> out_valid)

endmodule

bind utf32_to_utf8_utf16_encoder_top u32enc_checker u_u32enc_checker (.*);
